[design/hse_pkg.sv]
`default_nettype none

package hse_pkg;

    // op codes carried in s_tuser
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam int BYTE_W      = 8;
    localparam int CODE_BITS_W = 32;
    localparam int CODE_LEN_W  = 6;
    localparam int SYM_FIELD_W = 8;
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 2;

    // field positions in s_tdata
    localparam int SYM_LSB  = 0;
    localparam int BITS_LSB = SYM_LSB + SYM_FIELD_W;
    localparam int LEN_LSB  = BITS_LSB + CODE_BITS_W;

    // front-to-back command queue
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = QPTR_W + 1;

    typedef struct packed {
        logic full;
        logic not_empty;
    } hse_qstat_t;

endpackage

`default_nettype wire

[design/hse_front.sv]
`default_nettype none

module hse_front
    import hse_pkg::*;
#(
    parameter int NUM_SYMBOLS = 256,
    parameter int CODE_W      = 32,
    parameter int LW          = 6,
    parameter int SYM_W       = 8,
    parameter int QW          = 1 + CODE_W + LW
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    input  wire hse_qstat_t           q_stat,
    output logic                      push,
    output logic [QW-1:0]             push_data
);

    logic [1:0]             op;
    logic [SYM_FIELD_W-1:0] symbol;
    logic [CODE_BITS_W-1:0] code_bits;
    logic [CODE_LEN_W-1:0]  code_len;
    logic                   sym_ok;
    logic [SYM_W-1:0]       addr;
    logic [LW-1:0]          len_sat;
    logic                   accept;
    logic                   keep;
    logic                   wr_en;
    logic                   rd_en;

    logic [LW+CODE_W-1:0]   tbl_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] tbl_vld_reg;

    logic                   st_valid_reg, st_valid_next;
    logic                   st_flush_reg;
    logic [LW+CODE_W-1:0]   rd_data_reg;
    logic                   rd_vld_reg;

    logic [LW-1:0]          item_len;
    logic [CODE_W-1:0]      item_code;
    logic [LW-1:0]          shamt;
    logic [CODE_W-1:0]      aligned;
    logic                   need_push;
    logic                   st_done;

    assign op        = s_tuser;
    assign symbol    = s_tdata[SYM_LSB +: SYM_FIELD_W];
    assign code_bits = s_tdata[BITS_LSB +: CODE_BITS_W];
    assign code_len  = s_tdata[LEN_LSB +: CODE_LEN_W];

    assign sym_ok  = {1'b0, symbol} < (SYM_FIELD_W+1)'(NUM_SYMBOLS);
    assign addr    = symbol[SYM_W-1:0];
    assign len_sat = (code_len > CODE_LEN_W'(CODE_W)) ? LW'(CODE_W) : LW'(code_len);

    always_comb begin
        keep  = 1'b0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        unique case (op)
            OP_LOAD: begin
                wr_en = accept && sym_ok;
            end
            OP_ENCODE: begin
                keep  = sym_ok;
                rd_en = accept && sym_ok;
            end
            OP_FLUSH: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // table: code word and length in one word, length qualified by a valid bit
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[addr] <= {len_sat, code_bits[CODE_W-1:0]};
        end
        if (rd_en) begin
            rd_data_reg <= tbl_mem[addr];
            rd_vld_reg  <= tbl_vld_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_vld_reg <= '0;
        end else if (wr_en) begin
            tbl_vld_reg[addr] <= 1'b1;
        end
    end

    assign item_len  = rd_vld_reg ? rd_data_reg[CODE_W +: LW] : '0;
    assign item_code = rd_data_reg[CODE_W-1:0];
    // left-align the code so the back end always takes bits from the top
    assign shamt     = LW'(CODE_W) - item_len;
    assign aligned   = item_code << shamt;

    // zero-length encodes are dropped here
    assign need_push = st_flush_reg || (item_len != '0);
    assign st_done   = st_valid_reg && (!need_push || !q_stat.full);
    assign push      = st_valid_reg && need_push && !q_stat.full;
    assign push_data = {st_flush_reg, aligned, item_len};

    assign s_tready      = !st_valid_reg || st_done;
    assign accept        = s_tvalid && s_tready;
    assign st_valid_next = accept ? keep : (st_valid_reg && !st_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_flush_reg <= (op == OP_FLUSH);
        end
    end

endmodule

`default_nettype wire

[design/hse_queue.sv]
`default_nettype none

module hse_queue
    import hse_pkg::*;
#(
    parameter int W = 39
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic [W-1:0]      pop_data,
    output hse_qstat_t        q_stat
);

    logic [W-1:0]      q_ent_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
    assign cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);

    assign q_stat.full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_stat.not_empty = (cnt_reg != '0);
    assign pop_data         = q_ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[design/hse_back.sv]
`default_nettype none

module hse_back
    import hse_pkg::*;
#(
    parameter int CODE_W = 32,
    parameter int LW     = 6,
    parameter int QW     = 1 + CODE_W + LW
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire hse_qstat_t        q_stat,
    input  wire logic [QW-1:0]     pop_data,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,
    output logic                   m_tlast
);

    logic                wk_valid_reg, wk_valid_next;
    logic                wk_flush_reg, wk_flush_next;
    logic [CODE_W-1:0]   wk_word_reg, wk_word_next;
    logic [LW-1:0]       wk_rem_reg, wk_rem_next;
    logic [BYTE_W-1:0]   held_reg, held_next;
    logic [3:0]          hc_reg, hc_next;
    logic                ob_valid_reg, ob_valid_next;
    logic [BYTE_W-1:0]   ob_byte_reg, ob_byte_next;
    logic                ob_last_reg, ob_last_next;

    logic [6:0]          rem7;
    logic [3:0]          room;
    logic [3:0]          avail;
    logic [3:0]          take;
    logic                full_held;
    logic                need_emit;
    logic                ob_free;
    logic                step;
    logic                emit;
    logic                item_done;
    logic [CODE_W+7:0]   wx;
    logic [BYTE_W-1:0]   top8;
    logic [BYTE_W-1:0]   base;
    logic [15:0]         mix;
    logic [LW-1:0]       rem_after;
    logic [BYTE_W-1:0]   fl_byte;

    assign rem7      = 7'(wk_rem_reg);
    assign room      = 4'd8 - hc_reg;
    assign full_held = (hc_reg == 4'd8);
    assign avail     = (rem7 > 7'd8) ? 4'd8 : 4'(rem7);
    // a full held byte goes out first, then up to eight fresh bits come in
    assign take      = full_held ? avail : ((avail < room) ? avail : room);

    assign wx        = {wk_word_reg, 8'b0};
    assign top8      = wx[CODE_W+7 -: 8];
    assign base      = full_held ? 8'b0 : held_reg;
    assign mix       = {base, top8} << take;
    assign rem_after = wk_rem_reg - LW'(take);
    assign fl_byte   = held_reg << (4'd8 - hc_reg);

    assign need_emit = wk_flush_reg || full_held;
    assign ob_free   = !ob_valid_reg || m_tready;
    assign step      = wk_valid_reg && (!need_emit || ob_free);
    assign emit      = step && need_emit;
    assign item_done = step && (wk_flush_reg || (rem_after == '0));
    assign pop       = q_stat.not_empty && (!wk_valid_reg || item_done);

    always_comb begin
        wk_valid_next = wk_valid_reg;
        wk_flush_next = wk_flush_reg;
        wk_word_next  = wk_word_reg;
        wk_rem_next   = wk_rem_reg;
        held_next     = held_reg;
        hc_next       = hc_reg;
        ob_valid_next = ob_valid_reg && !m_tready;
        ob_byte_next  = ob_byte_reg;
        ob_last_next  = ob_last_reg;

        if (step) begin
            if (wk_flush_reg) begin
                held_next = '0;
                hc_next   = '0;
            end else begin
                held_next   = mix[15:8];
                hc_next     = full_held ? take : hc_reg + take;
                wk_word_next = wk_word_reg << take;
                wk_rem_next  = rem_after;
            end
        end

        if (emit) begin
            ob_valid_next = 1'b1;
            ob_byte_next  = wk_flush_reg ? fl_byte : held_reg;
            // no further byte for this item once the rest fits in the held byte
            ob_last_next  = wk_flush_reg || (rem7 <= 7'd8);
        end

        priority if (pop) begin
            wk_valid_next = 1'b1;
            wk_flush_next = pop_data[QW-1];
            wk_word_next  = pop_data[LW +: CODE_W];
            wk_rem_next   = pop_data[LW-1:0];
        end else if (item_done) begin
            wk_valid_next = 1'b0;
        end else begin
            wk_valid_next = wk_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wk_valid_reg <= 1'b0;
            held_reg     <= '0;
            hc_reg       <= '0;
            ob_valid_reg <= 1'b0;
        end else begin
            wk_valid_reg <= wk_valid_next;
            held_reg     <= held_next;
            hc_reg       <= hc_next;
            ob_valid_reg <= ob_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wk_flush_reg <= wk_flush_next;
        wk_word_reg  <= wk_word_next;
        wk_rem_reg   <= wk_rem_next;
        ob_byte_reg  <= ob_byte_next;
        ob_last_reg  <= ob_last_next;
    end

    assign m_tvalid = ob_valid_reg;
    assign m_tdata  = ob_byte_reg;
    assign m_tlast  = ob_last_reg;

endmodule

`default_nettype wire

[design/huffman_symbol_encoder.sv]
// A flush or encode byte passes the table read at acceptance, the queue push, the packer load
// and the output register on its way to m_.
// Throughput: one input beat per cycle while codes fit the held byte and the queue is not full;
// the packer takes up to eight code bits per cycle while the output register can take a byte.
// Output: at most one byte per cycle through a single output register.
// Reset: synchronous on aresetn low; clears the queue, packer and table valid bits at once.
`default_nettype none

module huffman_symbol_encoder
    import hse_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // symbol[7:0], code_bits[39:8], code_len[45:40]
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // op[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [BYTE_W-1:0]         m_tdata,   // out_byte[7:0]
    output logic                      m_tlast
);

    localparam int CODE_W = (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W;
    localparam int LW     = $clog2(CODE_W + 1);
    localparam int SYM_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int QW     = 1 + CODE_W + LW;

    hse_qstat_t    q_stat;
    logic          push;
    logic [QW-1:0] push_data;
    logic          pop;
    logic [QW-1:0] pop_data;

    hse_front #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .CODE_W      (CODE_W),
        .LW          (LW),
        .SYM_W       (SYM_W),
        .QW          (QW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    hse_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    hse_back #(
        .CODE_W (CODE_W),
        .LW     (LW),
        .QW     (QW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[design/hse_checker.sv]
`default_nettype none

module hse_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // nothing leaves the block straight after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // empty front end is ready again right after reset
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("s_tready low after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // within one item the next byte follows without a gap once a non-final byte is taken
    a_burst_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a multi-byte result burst");

endmodule

bind huffman_symbol_encoder hse_checker u_hse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hse_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 125;
    localparam int CHUNK        = 25;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int LEN_CAP      = 32;
    localparam int NO_TYPED     = -1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    // typed: expected bytes, first one in the low byte
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  sym;
        logic [31:0] bits;
        logic [5:0]  len;
        int          n_typed;
        logic [31:0] typed;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 m_tlast;

    // predictor copy of the code table and the byte packer
    logic [31:0] code_word_tbl [256];
    logic [5:0]  code_len_tbl  [256];
    logic [7:0]  pk_byte;
    logic [3:0]  pk_count;
    logic [7:0]  pred_bytes [4];
    int          pred_n;

    out_beat_t   pending_bytes [$];
    dir_row_t    dir_rows [$];
    logic [7:0]  loaded_syms [$];

    int  errors = 0;
    int  bytes_checked = 0;
    int  op_count [4] = '{0, 0, 0, 0};
    int  idle_cycles = 0;
    bit  steady = 1'b0;

    always #CLK_HALF aclk = ~aclk;

    huffman_symbol_encoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] op, input logic [7:0] sym,
                                        input logic [31:0] bits, input logic [5:0] len,
                                        input int n_typed, input logic [31:0] typed);
        dir_row_t r;
        r.op      = op;
        r.sym     = sym;
        r.bits    = bits;
        r.len     = len;
        r.n_typed = n_typed;
        r.typed   = typed;
        return r;
    endfunction

    task automatic predict_item(input logic [1:0] op, input logic [7:0] sym,
                                input logic [31:0] bits, input logic [5:0] len);
        int n_bits;
        pred_n = 0;
        case (op)
            OP_LOAD: begin
                code_word_tbl[sym] = bits;
                code_len_tbl[sym]  = (len > LEN_CAP) ? 6'(LEN_CAP) : len;
            end
            OP_ENCODE: begin
                n_bits = int'(code_len_tbl[sym]);
                for (int i = n_bits; i > 0; i--) begin
                    // a completed byte only leaves once the next bit turns up
                    if (pk_count == 4'd8) begin
                        pred_bytes[pred_n] = pk_byte;
                        pred_n++;
                        pk_byte  = '0;
                        pk_count = '0;
                    end
                    pk_byte  = {pk_byte[6:0], code_word_tbl[sym][i-1]};
                    pk_count = pk_count + 4'd1;
                end
            end
            OP_FLUSH: begin
                pred_bytes[0] = pk_byte << (4'd8 - pk_count);
                pred_n        = 1;
                pk_byte       = '0;
                pk_count      = '0;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] sym,
                             input logic [31:0] bits, input logic [5:0] len,
                             input int n_typed, input logic [31:0] typed);
        logic [S_TDATA_W-1:0] beat;
        int gap;
        beat = '0;
        beat[SYM_LSB +: SYM_FIELD_W] = sym;
        beat[BITS_LSB +: CODE_BITS_W] = bits;
        beat[LEN_LSB +: CODE_LEN_W] = len;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        predict_item(op, sym, bits, len);
        if (n_typed == NO_TYPED) begin
            for (int i = 0; i < pred_n; i++)
                pending_bytes.push_back('{data: pred_bytes[i], last: (i == pred_n - 1)});
        end else begin
            for (int i = 0; i < n_typed; i++)
                pending_bytes.push_back('{data: typed[8*i +: 8], last: (i == n_typed - 1)});
        end
        op_count[op]++;
    endtask

    // hold the sender off until every expected byte is out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_bytes.size() != 0);
    endtask

    initial begin
        int n;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(12, 1)) @(posedge aclk);
            n = steady ? 0 : pick_gap();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                $error("unexpected beat: out_byte %h last %b", m_tdata, m_tlast);
                errors++;
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_byte mismatch: expected %h, actual %h", want.data, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last mismatch: expected %b, actual %b", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("** huffman_symbol_encoder: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          n_random;
        int          iter;
        int          r;
        logic [1:0]  op;
        logic [7:0]  sym;
        logic [31:0] bits;
        logic [5:0]  len;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_LOAD;
        for (int i = 0; i < 256; i++)
            code_len_tbl[i] = '0;
        pk_byte  = '0;
        pk_count = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty flush, unloaded symbol, unused op, saturated length, full held byte
        dir_rows.push_back(mk_row(OP_FLUSH,  8'h00, 32'h0, 6'd0, 1, 32'h00));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'h00, 32'h0, 6'd0, 0, 32'h0));
        dir_rows.push_back(mk_row(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 0, 32'h0));
        dir_rows.push_back(mk_row(OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd63, 0, 32'h0));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'hFF, 32'h0, 6'd0, 3, 32'h00FF_FFFF));
        dir_rows.push_back(mk_row(OP_FLUSH,  8'h00, 32'h0, 6'd0, 1, 32'hFF));
        dir_rows.push_back(mk_row(OP_LOAD,   8'h00, 32'h0, 6'd1, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_LOAD,   8'h01, 32'h1, 6'd1, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'h01, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'h00, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'h01, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_FLUSH,  8'h00, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_LOAD,   8'h7E, 32'hDEAD_BEEF, 6'd32, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'h01, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'h7E, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_LOAD,   8'h55, 32'h1234_5678, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'h55, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_LOAD,   8'h10, 32'h8000_0001, 6'd33, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'h10, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_LOAD,   8'h20, 32'hFFFF_FFF5, 6'd3, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'h20, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_LOAD,   8'hFF, 32'h0000_0002, 6'd2, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_ENCODE, 8'hFF, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_FLUSH,  8'h00, 32'h0, 6'd0, NO_TYPED, 32'h0));
        dir_rows.push_back(mk_row(OP_FLUSH,  8'h00, 32'h0, 6'd0, NO_TYPED, 32'h0));

        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].op, dir_rows[k].sym, dir_rows[k].bits, dir_rows[k].len,
                      dir_rows[k].n_typed, dir_rows[k].typed);
            if (dir_rows[k].op == OP_LOAD)
                loaded_syms.push_back(dir_rows[k].sym);
        end
        wait_drained();

        n_random = 0;
        iter = 0;
        while (n_random < RANDOM_ITEMS) begin
            if (iter % CHUNK == 0) begin
                steady = ($urandom_range(3) == 0);
                if (iter > 0 && $urandom_range(1) == 1)
                    wait_drained();
            end
            iter++;
            r    = $urandom_range(99);
            sym  = 8'($urandom_range(255));
            bits = $urandom;
            len  = '0;
            if (r < 4) begin
                op  = OP_UNUSED;
                len = 6'($urandom_range(63));
            end else if (r < 20) begin
                op = OP_LOAD;
                r  = $urandom_range(99);
                if (r < 70)      len = 6'($urandom_range(9, 1));
                else if (r < 85) len = 6'($urandom_range(32, 10));
                else if (r < 95) len = 6'($urandom_range(63, 33));
                loaded_syms.push_back(sym);
            end else if (r < 30) begin
                op = OP_FLUSH;
            end else begin
                // mostly symbols with a code, now and then an arbitrary one
                op = OP_ENCODE;
                if ($urandom_range(9) < 8)
                    sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
            end
            send_item(op, sym, bits, len, NO_TYPED, 32'h0);
            if (op != OP_UNUSED)
                n_random++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d loads, %0d encodes, %0d flushes and %0d unused-op beats;",
                 op_count[OP_LOAD], op_count[OP_ENCODE], op_count[OP_FLUSH],
                 op_count[OP_UNUSED]);
        $display("%0d output bytes compared under random gaps and stalls.", bytes_checked);
        if (errors == 0 && pending_bytes.size() == 0) begin
            $display("** huffman_symbol_encoder: PASSED **");
        end else begin
            $display("** huffman_symbol_encoder: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
design/hse_pkg.sv
design/hse_front.sv
design/hse_queue.sv
design/hse_back.sv
design/huffman_symbol_encoder.sv
design/hse_checker.sv
dv/tb.sv
